[hdl/cct_pkg.sv]
// Shared types, constants and isotherm tables for the color temperature core.
package cct_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int TEMP_BITS_DEF  = 20;

   localparam int NISO       = 31;
   localparam int ENT_W      = 5;
   localparam int UV_FRAC    = 20;
   localparam int MIRED_FRAC = 12;
   localparam int D_W        = 24;
   localparam int S_W        = 25;
   localparam int N_W        = 24;
   localparam int MIRED_W    = 22;
   localparam int PROD_W     = 48;

   // shared divider sizing, covers every legal COORD_BITS / TEMP_BITS
   localparam int DIV_NUM_W = 48;
   localparam int DIV_DEN_W = 28;
   localparam int DIV_Q_W   = 28;
   localparam int DIV_CNT_W = 5;

   localparam logic [DIV_CNT_W-1:0] UV_QBITS   = 5'd24;
   localparam logic [DIV_CNT_W-1:0] DIST_QBITS = 5'd24;
   localparam logic [DIV_CNT_W-1:0] INTP_QBITS = 5'd18;

   localparam logic [UV_FRAC-1:0]    UV_MAX = {UV_FRAC{1'b1}};
   localparam logic signed [D_W-1:0] D_MAX  = 24'sh7fffff;
   localparam logic signed [D_W-1:0] D_MIN  = 24'sh800000;
   localparam logic [DIV_NUM_W-1:0]  K_NUM  = 48'd4096000000; // 1e6 in Q.12

   // divider operations
   localparam logic [2:0] OP_U      = 3'd0;
   localparam logic [2:0] OP_V      = 3'd1;
   localparam logic [2:0] OP_DIST   = 3'd2;
   localparam logic [2:0] OP_INTERP = 3'd3;
   localparam logic [2:0] OP_KELV   = 3'd4;

   typedef struct packed {
      logic       load_in;
      logic       ent_clr;
      logic       div_start;
      logic       latch;
      logic [2:0] op;
      logic       prod;
      logic       sum;
      logic       shift_d;
      logic       ent_inc;
      logic       mprod;
      logic       mired_base;
      logic       kelv_sat;
      logic       res_err;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic ent_zero;
      logic ent_last;
      logic found;
      logic d0_zero;
      logic mired_zero;
      logic out_free;
   } stat_type;

   typedef longint rom5_type [NISO];
   typedef logic [UV_FRAC-1:0] uv_tab_type [NISO];
   typedef logic signed [S_W-1:0] slope_tab_type [NISO];
   typedef logic [N_W-1:0] norm_tab_type [NISO];
   typedef logic [9:0] mired_tab_type [NISO];

   localparam rom5_type ROM_U5 = '{
      18006, 18066, 18133, 18208, 18293, 18388, 18494, 18611, 18740, 18880,
      19032, 19462, 19962, 20525, 21142, 21807, 22511, 23247, 24010, 24792,
      25591, 26400, 27218, 28039, 28863, 29685, 30505, 31320, 32129, 32931,
      33724};
   localparam rom5_type ROM_V5 = '{
      26350, 26589, 26846, 27119, 27407, 27709, 28021, 28342, 28668, 28997,
      29326, 30141, 30921, 31647, 32312, 32909, 33439, 33904, 34308, 34655,
      34951, 35200, 35407, 35577, 35714, 35823, 35907, 35968, 36011, 36038,
      36051};
   localparam rom5_type ROM_S5 = '{
      -24341, -25479, -26876, -28539, -30740, -32675, -35156, -37915, -40955,
      -44278, -47888, -58204, -70471, -84901, -101820, -121680, -145120,
      -172980, -206370, -246810, -296410, -358140, -436330, -537620, -672620,
      -859550, -1132400, -1562800, -2332500, -4077000, -11645000};
   localparam mired_tab_type MIRED_TAB = '{
      10'd0, 10'd10, 10'd20, 10'd30, 10'd40, 10'd50, 10'd60, 10'd70, 10'd80,
      10'd90, 10'd100, 10'd125, 10'd150, 10'd175, 10'd200, 10'd225, 10'd250,
      10'd275, 10'd300, 10'd325, 10'd350, 10'd375, 10'd400, 10'd425, 10'd450,
      10'd475, 10'd500, 10'd525, 10'd550, 10'd575, 10'd600};

   // 1e-5 units to Q0.20, round half up
   function automatic uv_tab_type build_q20(input rom5_type src);
      uv_tab_type res;
      longint     t;
      for (int i = 0; i < NISO; i++) begin
         t = (src[i] * 64'sd1048576 + 64'sd50000) / 64'sd100000;
         res[i] = t[UV_FRAC-1:0];
      end
      return res;
   endfunction

   function automatic slope_tab_type build_slope(input rom5_type src);
      slope_tab_type res;
      for (int i = 0; i < NISO; i++) begin
         res[i] = src[i][S_W-1:0];
      end
      return res;
   endfunction

   // floor(sqrt(1e10 + s^2)), evaluated at elaboration
   function automatic norm_tab_type build_norm(input rom5_type src);
      norm_tab_type    res;
      longint unsigned n;
      longint unsigned r;
      longint unsigned b;
      for (int i = 0; i < NISO; i++) begin
         n = 64'd10000000000 + longint'(src[i] * src[i]);
         r = 0;
         b = 64'd1 << 62;
         for (int k = 0; k < 32; k++) begin
            if (n >= r + b) begin
               n = n - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         res[i] = r[N_W-1:0];
      end
      return res;
   endfunction

   localparam uv_tab_type    RU_TAB    = build_q20(ROM_U5);
   localparam uv_tab_type    RV_TAB    = build_q20(ROM_V5);
   localparam slope_tab_type SLOPE_TAB = build_slope(ROM_S5);
   localparam norm_tab_type  NORM_TAB  = build_norm(ROM_S5);

endpackage

[hdl/cct_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle, with overflow flag.
module cct_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cct_pkg::DIV_NUM_W-1:0] num,
   input  logic [cct_pkg::DIV_DEN_W-1:0] den,
   input  logic [cct_pkg::DIV_CNT_W-1:0] qbits,
   output logic                          done,
   output logic                          over,
   output logic [cct_pkg::DIV_Q_W-1:0]   quot
);

   localparam int NW = cct_pkg::DIV_NUM_W;
   localparam int DW = cct_pkg::DIV_DEN_W;
   localparam int QW = cct_pkg::DIV_Q_W;
   localparam int CW = cct_pkg::DIV_CNT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [NW-1:0] nsh_ff, nsh_in;
   logic [QW-1:0] q_ff, q_in;
   logic          over_ff, over_in;

   logic [NW-1:0] num_hi;
   logic          ovf_now;
   logic [DW:0]   trial;
   logic          ge;

   always_comb begin
      num_hi  = num >> qbits;
      ovf_now = num_hi >= NW'(den);
      trial   = {rem_ff, nsh_ff[NW-1]};
      ge      = trial >= {1'b0, den_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      nsh_in  = nsh_ff;
      q_in    = q_ff;
      over_in = over_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = ovf_now ? '0 : qbits;
         rem_in  = num_hi[DW-1:0];
         den_in  = den;
         nsh_in  = num << (7'(NW) - 7'(qbits));
         q_in    = '0;
         over_in = ovf_now;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            nsh_in = nsh_ff << 1;
            q_in   = {q_ff[QW-2:0], ge};
            rem_in = ge ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      nsh_ff  <= nsh_in;
      q_ff    <= q_in;
      over_ff <= over_in;
   end

   assign done = done_ff;
   assign over = over_ff;
   assign quot = q_ff;

endmodule

[hdl/cct_datapath.sv]
// Datapath: uv conversion, isotherm distances, mired interpolation, kelvin.
module cct_datapath #(
   parameter int COORD_BITS = cct_pkg::COORD_BITS_DEF,
   parameter int TEMP_BITS  = cct_pkg::TEMP_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cct_pkg::cmd_type       cmd,
   output cct_pkg::stat_type      stat,
   input  logic [15:0]            x_in,
   input  logic [15:0]            y_in,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [TEMP_BITS-1:0]   kelvin_out,
   output logic                   status_out,
   output logic [4:0]             brk_out
);

   localparam int NW   = cct_pkg::DIV_NUM_W;
   localparam int DW   = cct_pkg::DIV_DEN_W;
   localparam int QW   = cct_pkg::DIV_Q_W;
   localparam int CW   = cct_pkg::DIV_CNT_W;
   localparam int UVW  = cct_pkg::UV_FRAC;
   localparam int DDW  = cct_pkg::D_W;
   localparam int MW   = cct_pkg::MIRED_W;
   localparam int PW   = cct_pkg::PROD_W;
   localparam int EW   = cct_pkg::ENT_W;
   localparam int UVDW = COORD_BITS + 4;
   localparam logic [TEMP_BITS-1:0] K_MAX = {TEMP_BITS{1'b1}};
   localparam logic signed [17:0]   E5    = 18'sd100000;

   logic [COORD_BITS-1:0] x_ff, y_ff;
   logic [UVW-1:0]        u_ff, v_ff;
   logic signed [PW-1:0]  p1_ff, p2_ff;
   logic [NW-1:0]         dnum_ff;
   logic                  dneg_ff;
   logic signed [DDW-1:0] d0_ff, d1_ff;
   logic [EW-1:0]         ent_ff;
   logic [40:0]           mprod_ff;
   logic [24:0]           adiff_ff;
   logic [MW-1:0]         mired_ff;
   logic [TEMP_BITS-1:0]  kel_ff;
   logic                  err_ff;
   logic                  rsp_valid_ff;
   logic [TEMP_BITS-1:0]  rsp_kel_ff;
   logic                  rsp_err_ff;
   logic [4:0]            rsp_brk_ff;

   logic [31:0]           x_ext, y_ext;
   logic [UVDW-1:0]       den_uv;
   logic [NW-1:0]         num_u, num_v;
   logic signed [21:0]    du, dv;
   logic signed [39:0]    p1_w;
   logic signed [46:0]    p2_w;
   logic signed [PW-1:0]  pdiff;
   logic [PW-1:0]         pmag;
   logic signed [25:0]    d0x, ddx;
   logic [23:0]           ad;
   logic [24:0]           adiff_w;
   logic [9:0]            m0, m1;
   logic [16:0]           dm;
   logic [MW-1:0]         m0q;
   logic signed [DDW-1:0] dist_q;
   logic [QW-1:0]         quot;
   logic                  over, done;
   logic                  div_start;
   logic [NW-1:0]         div_num;
   logic [DW-1:0]         div_den;
   logic [CW-1:0]         div_qbits;

   always_comb begin
      x_ext  = {16'd0, x_in};
      y_ext  = {16'd0, y_in};
      den_uv = UVDW'(y_ff) * UVDW'(6) + (UVDW'(3) << (COORD_BITS - 1)) - UVDW'(x_ff);
      num_u  = (NW'(x_ff) << (UVW + 1)) + NW'(den_uv >> 1);
      num_v  = ((NW'(y_ff) * NW'(3)) << UVW) + NW'(den_uv >> 1);

      du    = $signed({2'b00, u_ff}) - $signed({2'b00, cct_pkg::RU_TAB[ent_ff]});
      dv    = $signed({2'b00, v_ff}) - $signed({2'b00, cct_pkg::RV_TAB[ent_ff]});
      p1_w  = dv * E5;
      p2_w  = cct_pkg::SLOPE_TAB[ent_ff] * du;
      pdiff = p1_ff - p2_ff;
      pmag  = pdiff[PW-1] ? PW'(-pdiff) : PW'(pdiff);

      d0x     = 26'(d0_ff);
      ddx     = 26'(d0_ff) - 26'(d1_ff);
      ad      = d0x[25] ? 24'(-d0x) : 24'(d0x);
      adiff_w = ddx[25] ? 25'(-ddx) : 25'(ddx);
      // bracket is (ent - 1, ent)
      m0  = cct_pkg::MIRED_TAB[EW'(ent_ff - 1'b1)];
      m1  = cct_pkg::MIRED_TAB[ent_ff];
      dm  = 17'(m1 - m0) << cct_pkg::MIRED_FRAC;
      m0q = MW'(m0) << cct_pkg::MIRED_FRAC;

      // signed saturation of the distance quotient
      if (over) begin
         dist_q = dneg_ff ? cct_pkg::D_MIN : cct_pkg::D_MAX;
      end else if (dneg_ff) begin
         dist_q = (quot[23:0] > 24'h800000) ? cct_pkg::D_MIN : DDW'(-$signed({1'b0, quot[23:0]}));
      end else begin
         dist_q = quot[23] ? cct_pkg::D_MAX : $signed(quot[23:0]);
      end

      div_start = cmd.div_start;
      case (cmd.op)
         cct_pkg::OP_U: begin
            div_num   = num_u;
            div_den   = DW'(den_uv);
            div_qbits = cct_pkg::UV_QBITS;
         end
         cct_pkg::OP_V: begin
            div_num   = num_v;
            div_den   = DW'(den_uv);
            div_qbits = cct_pkg::UV_QBITS;
         end
         cct_pkg::OP_DIST: begin
            div_num   = dnum_ff;
            div_den   = DW'(cct_pkg::NORM_TAB[ent_ff]);
            div_qbits = cct_pkg::DIST_QBITS;
         end
         cct_pkg::OP_INTERP: begin
            div_num   = NW'(mprod_ff) + NW'(adiff_ff >> 1);
            div_den   = DW'(adiff_ff);
            div_qbits = cct_pkg::INTP_QBITS;
         end
         cct_pkg::OP_KELV: begin
            div_num   = cct_pkg::K_NUM + NW'(mired_ff >> 1);
            div_den   = DW'(mired_ff);
            div_qbits = CW'(TEMP_BITS);
         end
         default: begin
            div_num   = '0;
            div_den   = '0;
            div_qbits = '0;
         end
      endcase
   end

   cct_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .qbits (div_qbits),
      .done  (done),
      .over  (over),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         x_ff   <= x_ext[COORD_BITS-1:0];
         y_ff   <= y_ext[COORD_BITS-1:0];
         err_ff <= 1'b0;
      end
      if (cmd.ent_clr) begin
         ent_ff <= '0;
      end else if (cmd.ent_inc) begin
         ent_ff <= ent_ff + 1'b1;
      end
      if (cmd.prod) begin
         p1_ff <= PW'(p1_w);
         p2_ff <= PW'(p2_w);
      end
      if (cmd.sum) begin
         dnum_ff <= pmag + NW'(cct_pkg::NORM_TAB[ent_ff] >> 1);
         dneg_ff <= pdiff[PW-1];
      end
      if (cmd.shift_d) begin
         d0_ff <= d1_ff;
      end
      if (cmd.mprod) begin
         mprod_ff <= 41'(ad * dm);
         adiff_ff <= adiff_w;
      end
      if (cmd.mired_base) begin
         mired_ff <= m0q;
      end
      if (cmd.kelv_sat) begin
         kel_ff <= K_MAX;
      end
      if (cmd.res_err) begin
         err_ff <= 1'b1;
      end
      if (cmd.latch) begin
         case (cmd.op)
            cct_pkg::OP_U:      u_ff <= (over || (|quot[23:UVW])) ? cct_pkg::UV_MAX
                                                                    : quot[UVW-1:0];
            cct_pkg::OP_V:      v_ff <= (over || (|quot[23:UVW])) ? cct_pkg::UV_MAX
                                                                    : quot[UVW-1:0];
            cct_pkg::OP_DIST:   d1_ff <= dist_q;
            cct_pkg::OP_INTERP: mired_ff <= m0q + MW'(quot[17:0]);
            cct_pkg::OP_KELV:   kel_ff <= over ? K_MAX : quot[TEMP_BITS-1:0];
            default: ;
         endcase
      end
      if (cmd.out_load) begin
         rsp_kel_ff <= err_ff ? '0 : kel_ff;
         rsp_err_ff <= err_ff;
         rsp_brk_ff <= err_ff ? 5'd0 : 5'(ent_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      stat.div_done   = done;
      stat.ent_zero   = ent_ff == '0;
      stat.ent_last   = ent_ff == EW'(cct_pkg::NISO - 1);
      stat.found      = (d1_ff == '0) || (d0_ff == '0) || (d0_ff[DDW-1] != d1_ff[DDW-1]);
      stat.d0_zero    = d0_ff == '0;
      stat.mired_zero = mired_ff == '0;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign kelvin_out = rsp_kel_ff;
   assign status_out = rsp_err_ff;
   assign brk_out    = rsp_brk_ff;

endmodule

[hdl/cct_ctrl.sv]
// Controller: sequences uv conversion, the isotherm walk and the final divisions.
module cct_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cct_pkg::stat_type stat,
   output cct_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_U_GO    = 4'd1;
   localparam logic [3:0] S_U_WAIT  = 4'd2;
   localparam logic [3:0] S_V_GO    = 4'd3;
   localparam logic [3:0] S_V_WAIT  = 4'd4;
   localparam logic [3:0] S_D_PROD  = 4'd5;
   localparam logic [3:0] S_D_SUM   = 4'd6;
   localparam logic [3:0] S_D_GO    = 4'd7;
   localparam logic [3:0] S_D_WAIT  = 4'd8;
   localparam logic [3:0] S_D_CHECK = 4'd9;
   localparam logic [3:0] S_M_PROD  = 4'd10;
   localparam logic [3:0] S_M_GO    = 4'd11;
   localparam logic [3:0] S_M_WAIT  = 4'd12;
   localparam logic [3:0] S_K_GO    = 4'd13;
   localparam logic [3:0] S_K_WAIT  = 4'd14;
   localparam logic [3:0] S_OUT     = 4'd15;

   logic [3:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      in_ready = state_ff == S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd.load_in = 1'b1;
               cmd.ent_clr = 1'b1;
               state_in    = S_U_GO;
            end
         end
         S_U_GO: begin
            cmd.op        = cct_pkg::OP_U;
            cmd.div_start = 1'b1;
            state_in      = S_U_WAIT;
         end
         S_U_WAIT: begin
            cmd.op = cct_pkg::OP_U;
            if (stat.div_done) begin
               cmd.latch = 1'b1;
               state_in  = S_V_GO;
            end
         end
         S_V_GO: begin
            cmd.op        = cct_pkg::OP_V;
            cmd.div_start = 1'b1;
            state_in      = S_V_WAIT;
         end
         S_V_WAIT: begin
            cmd.op = cct_pkg::OP_V;
            if (stat.div_done) begin
               cmd.latch = 1'b1;
               state_in  = S_D_PROD;
            end
         end
         S_D_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_D_SUM;
         end
         S_D_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_D_GO;
         end
         S_D_GO: begin
            cmd.op        = cct_pkg::OP_DIST;
            cmd.div_start = 1'b1;
            state_in      = S_D_WAIT;
         end
         S_D_WAIT: begin
            cmd.op = cct_pkg::OP_DIST;
            if (stat.div_done) begin
               cmd.latch = 1'b1;
               state_in  = S_D_CHECK;
            end
         end
         S_D_CHECK: begin
            // first isotherm only primes d0
            if (stat.ent_zero) begin
               cmd.shift_d = 1'b1;
               cmd.ent_inc = 1'b1;
               state_in    = S_D_PROD;
            end else if (stat.found) begin
               state_in = S_M_PROD;
            end else if (stat.ent_last) begin
               cmd.res_err = 1'b1;
               state_in    = S_OUT;
            end else begin
               cmd.shift_d = 1'b1;
               cmd.ent_inc = 1'b1;
               state_in    = S_D_PROD;
            end
         end
         S_M_PROD: begin
            // point on the lower isotherm: take its mired as is
            if (stat.d0_zero) begin
               cmd.mired_base = 1'b1;
               state_in       = S_K_GO;
            end else begin
               cmd.mprod = 1'b1;
               state_in  = S_M_GO;
            end
         end
         S_M_GO: begin
            cmd.op        = cct_pkg::OP_INTERP;
            cmd.div_start = 1'b1;
            state_in      = S_M_WAIT;
         end
         S_M_WAIT: begin
            cmd.op = cct_pkg::OP_INTERP;
            if (stat.div_done) begin
               cmd.latch = 1'b1;
               state_in  = S_K_GO;
            end
         end
         S_K_GO: begin
            if (stat.mired_zero) begin
               cmd.kelv_sat = 1'b1;
               state_in     = S_OUT;
            end else begin
               cmd.op        = cct_pkg::OP_KELV;
               cmd.div_start = 1'b1;
               state_in      = S_K_WAIT;
            end
         end
         S_K_WAIT: begin
            cmd.op = cct_pkg::OP_KELV;
            if (stat.div_done) begin
               cmd.latch = 1'b1;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/correlated_color_temperature_core.sv]
// Robertson isotherm color temperature core: xy chromaticity in, kelvin out.
// Takes one xy transaction at a time and returns one result transaction for it.
// All divisions share a single restoring divider that produces one quotient bit
// per cycle, so the run time is set by that unit and by the isotherm walk, which
// visits 2 to 31 isotherms, and then, where needed, by the mired interpolation
// and the kelvin division. A new transaction is taken as soon as the previous
// one is finished, even while its result still waits in the output register.
module correlated_color_temperature_core #(
   parameter int COORD_BITS = cct_pkg::COORD_BITS_DEF,
   parameter int TEMP_BITS  = cct_pkg::TEMP_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [31:0]                          req_tdata,  // x_chroma, y_chroma
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((TEMP_BITS + 12) / 8) * 8-1:0] rsp_tdata,  // kelvin, bracket_index
   output logic [0:0]                           rsp_tuser   // status
);

   localparam int RSP_W = ((TEMP_BITS + 12) / 8) * 8;

   cct_pkg::cmd_type  cmd;
   cct_pkg::stat_type stat;
   logic [TEMP_BITS-1:0] kelvin;
   logic                 status;
   logic [4:0]           brk;

   cct_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .stat     (stat),
      .cmd      (cmd)
   );

   cct_datapath #(
      .COORD_BITS (COORD_BITS),
      .TEMP_BITS  (TEMP_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .x_in       (req_tdata[15:0]),
      .y_in       (req_tdata[31:16]),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .kelvin_out (kelvin),
      .status_out (status),
      .brk_out    (brk)
   );

   assign rsp_tdata = RSP_W'({brk, kelvin});
   assign rsp_tuser = status;

endmodule

[hdl/cct_checker.sv]
// Port-level checks for the color temperature core, bound to the top level.
module cct_checker #(
   parameter int TEMP_BITS = cct_pkg::TEMP_BITS_DEF
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [((TEMP_BITS + 12) / 8) * 8-1:0] rsp_tdata,
   input logic [0:0]                           rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // an error result carries zero kelvin and index
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[TEMP_BITS+4:0] == '0)
      else $error("error result with nonzero payload");

   a_brk_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[TEMP_BITS+4:TEMP_BITS] <= 5'd29)
      else $error("bracket index out of range");

   // one transaction at a time, so the input side closes right after a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after accept");

endmodule

bind correlated_color_temperature_core cct_checker #(.TEMP_BITS(TEMP_BITS)) u_cct_checker (.*);

[bench/correlated_color_temperature_core_tb.sv]
// Self-checking testbench for the isotherm color temperature core.
`timescale 1ns / 1ps

module correlated_color_temperature_core_tb;

   typedef struct packed {
      logic [15:0] y_chroma;
      logic [15:0] x_chroma;
   } chroma_type;

   typedef struct {
      logic [19:0] kelvin;
      logic        status;
      logic [4:0]  bracket_index;
   } cct_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;  // x_chroma, y_chroma
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;  // kelvin, bracket_index
   logic [0:0]  rsp_tuser;  // status

   chroma_type pending_chroma[$];
   cct_type    expected_cct[$];
   int         error_count;
   bit         req_took;
   bit         long_hold;
   int         gap_left;
   int         burst_left;
   int         stall_mode;
   int         mode_left;

   correlated_color_temperature_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint to_q20(input longint val5);
      return (val5 * 64'sd1048576 + 64'sd50000) / 64'sd100000;
   endfunction

   // signed distance of (u,v) from isotherm idx, Q3.20, rounded away from zero
   function automatic longint isotherm_distance(input longint u, input longint v,
                                                input int idx);
      longint du, dv, s, nrm, num, mag, d;
      du = u - to_q20(cct_pkg::ROM_U5[idx]);
      dv = v - to_q20(cct_pkg::ROM_V5[idx]);
      s = cct_pkg::ROM_S5[idx];
      nrm = longint'(int_sqrt(64'd10000000000 + longint'(s * s)));
      num = dv * 100000 - s * du;
      mag = num < 0 ? -num : num;
      mag = (mag + nrm / 2) / nrm;
      d = num < 0 ? -mag : mag;
      if (d > 8388607) d = 8388607;
      if (d < -8388608) d = -8388608;
      return d;
   endfunction

   function automatic cct_type predict_cct(input chroma_type c);
      cct_type r;
      longint x, y, den, u, v, d0, d1, m0, dm, mired, kel, ad, adiff;
      int     i;
      bit     found;
      x = c.x_chroma;
      y = c.y_chroma;
      den = 6 * y - x + (64'sd3 << 15);
      u = (((2 * x) << 20) + den / 2) / den;
      v = (((3 * y) << 20) + den / 2) / den;
      if (u > 1048575) u = 1048575;
      if (v > 1048575) v = 1048575;
      d0 = isotherm_distance(u, v, 0);
      d1 = 0;
      found = 0;
      for (i = 0; i < cct_pkg::NISO - 1; i++) begin
         d1 = isotherm_distance(u, v, i + 1);
         if (d1 == 0 || d0 == 0 || ((d0 < 0) != (d1 < 0))) begin
            found = 1;
            break;
         end
         d0 = d1;
      end
      if (!found) begin
         r.kelvin = '0;
         r.status = 1'b1;
         r.bracket_index = '0;
         return r;
      end
      m0 = longint'(cct_pkg::MIRED_TAB[i]) << 12;
      dm = (longint'(cct_pkg::MIRED_TAB[i + 1]) - longint'(cct_pkg::MIRED_TAB[i])) << 12;
      mired = m0;
      if (d0 != 0) begin
         ad = d0 < 0 ? -d0 : d0;
         adiff = d0 - d1;
         if (adiff < 0) adiff = -adiff;
         mired = mired + (ad * dm + adiff / 2) / adiff;
      end
      if (mired == 0) kel = 1048575;
      else begin
         kel = ((64'sd1000000 << 12) + mired / 2) / mired;
         if (kel > 1048575) kel = 1048575;
      end
      r.kelvin = kel[19:0];
      r.status = 1'b0;
      r.bracket_index = i[4:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      error_count++;
   endtask

   // driver: bursts of transactions separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         gap_left = 0;
         burst_left = 1;
      end else if (!(req_tvalid && !req_took)) begin
         req_took = 0;
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_chroma.size() > 0) begin
            req_tdata <= pending_chroma.pop_front();
            req_tvalid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 6);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 400);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_mode = 0;
         mode_left = 0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 3000);
         end
         mode_left--;
         if (long_hold) rsp_tready <= 1'b0;
         else if (stall_mode == 0) rsp_tready <= 1'b1;
         else if (stall_mode == 1) rsp_tready <= ($urandom_range(0, 2) != 0);
         else rsp_tready <= ($urandom_range(0, 7) == 0);
      end
   end

   // input acceptance and result monitor
   always @(posedge clock) begin
      cct_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_cct.push_back(predict_cct(chroma_type'(req_tdata)));
            req_took = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cct.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_tdata));
            end else begin
               want = expected_cct.pop_front();
               if (rsp_tdata[19:0] !== want.kelvin)
                  report_mismatch($sformatf("kelvin %0d, want %0d",
                                            rsp_tdata[19:0], want.kelvin));
               if (rsp_tuser[0] !== want.status)
                  report_mismatch($sformatf("status %b, want %b",
                                            rsp_tuser[0], want.status));
               if (rsp_tdata[24:20] !== want.bracket_index)
                  report_mismatch($sformatf("bracket %0d, want %0d",
                                            rsp_tdata[24:20], want.bracket_index));
            end
         end
      end
   end

   initial begin
      long_hold = 0;
      wait (!reset);
      repeat (30000) @(posedge clock);
      long_hold = 1;
      repeat (6000) @(posedge clock);
      long_hold = 0;
   end

   initial begin
      #400ms;
      $display("** correlated_color_temperature_core: FAILED **");
      $finish;
   end

   initial begin
      chroma_type c;
      real        ru, rv, dd;
      int         iso_pick[5] = '{0, 1, 10, 19, 30};
      error_count = 0;
      req_took = 0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // field extremes, large u, common white points
      pending_chroma.push_back('{16'h0000, 16'h0000});
      pending_chroma.push_back('{16'hffff, 16'hffff});
      pending_chroma.push_back('{16'h0000, 16'hffff});
      pending_chroma.push_back('{16'hffff, 16'h0000});
      pending_chroma.push_back('{16'h0001, 16'hfffe});
      pending_chroma.push_back('{16'd21561, 16'd20493});
      pending_chroma.push_back('{16'd26953, 16'd29299});
      pending_chroma.push_back('{16'd21843, 16'd21845});
      pending_chroma.push_back('{16'd17000, 16'd17500});
      pending_chroma.push_back('{16'd26500, 16'd40000});
      // points on or next to an isotherm, incl. zero mired and 100000 K entries
      foreach (iso_pick[k]) begin
         ru = cct_pkg::ROM_U5[iso_pick[k]] / 1.0e5;
         rv = cct_pkg::ROM_V5[iso_pick[k]] / 1.0e5;
         dd = 2.0 * ru - 8.0 * rv + 4.0;
         c.x_chroma = $rtoi(3.0 * ru / dd * 65536.0 + 0.5);
         c.y_chroma = $rtoi(2.0 * rv / dd * 65536.0 + 0.5);
         pending_chroma.push_back(c);
         c.x_chroma++;
         pending_chroma.push_back(c);
      end

      // random part: mostly the bracketed region, the rest full range
      for (int n = 0; n < 1950; n++) begin
         if ($urandom_range(0, 2) == 0) begin
            c = $urandom;
         end else begin
            c.x_chroma = $urandom_range(9000, 43000);
            c.y_chroma = $urandom_range(11000, 33000);
         end
         pending_chroma.push_back(c);
      end

      while (pending_chroma.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_cct.size() > 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      if (error_count == 0) begin
         $display("** correlated_color_temperature_core: PASSED **");
      end else begin
         $display("** correlated_color_temperature_core: FAILED **");
      end
      $finish;
   end

endmodule
